// ===== sv/multilevel_feedback_cpu_scheduler_macros.svh =====
// assertion macros used by the checker
`ifndef MULTILEVEL_FEEDBACK_CPU_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_CPU_SCHEDULER_MACROS_SVH

// condition must hold on every clock edge out of reset
`define MFCS_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("mfcs check failed");

// consequent must hold in the cycle after the antecedent
`define MFCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mfcs check failed");

`endif

// ===== sv/mfcs_pkg.sv =====
`default_nettype none
package mfcs_pkg;

    localparam int NUM_CPUS   = 4;
    localparam int NUM_LEVELS = 4;
    localparam int MAX_PROCS  = 16;

    localparam int CPU_W  = 2;
    localparam int LVL_W  = 2;
    localparam int PID_W  = 4;
    localparam int MODE_W = 3;
    localparam int SLICE_W = 8;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int ADDR_W = LVL_W + PID_W;
    localparam int DEPTH  = NUM_LEVELS * MAX_PROCS;
    localparam int PADDR_W = 3;

    localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd4;

    localparam logic [MODE_W-1:0] MODE_PASS   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RETIRE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLOCK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TERM   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADMIT  = 3'd4;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    localparam logic POLICY_PRIO = 1'b0;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    typedef enum logic [1:0] {
        PS_FREE  = 2'd0,
        PS_READY = 2'd1,
        PS_RUN   = 2'd2,
        PS_BLOCK = 2'd3
    } proc_state_t;

endpackage
`default_nettype wire

// ===== sv/mfcs_ram.sv =====
`default_nettype none
module mfcs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire  [WIDTH-1:0]          wr_data,
    input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== sv/multilevel_feedback_cpu_scheduler.sv =====
// retire, block, terminate, admit and any unknown mode give one result in the cycle after the request
// schedule pass: one result per cpu, each after the previous is taken, produced by
// the check step, the level scan (one level a cycle) and, on a refill, the queue ram read
// a new request is taken only once the last result of the previous one is taken
// reset (aresetn low, synchronous): all cpus idle, queues empty, all processes free
`default_nettype none
module multilevel_feedback_cpu_scheduler (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [mfcs_pkg::MODE_W-1:0]   s_mode,
    input  wire  [mfcs_pkg::CPU_W-1:0]    s_cpu_index,
    input  wire  [mfcs_pkg::PID_W-1:0]    s_process_id,
    input  wire  [mfcs_pkg::LVL_W-1:0]    s_start_level,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [mfcs_pkg::CPU_W-1:0]    m_cpu_number,
    output logic                          m_cpu_busy,
    output logic [mfcs_pkg::PID_W-1:0]    m_running_process,
    output logic                          m_preempt_valid,
    output logic [mfcs_pkg::PID_W-1:0]    m_preempted_process,
    output logic                          m_status,
    output logic                          m_last,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [mfcs_pkg::PADDR_W-1:0]  paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mfcs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FILL  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                 policy_reg;
    logic [SLICE_W-1:0]   quantum_reg;

    logic [PID_W-1:0]     head_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]     count_reg [NUM_LEVELS];
    logic [LVL_W-1:0]     plevel_reg [MAX_PROCS];
    proc_state_t          pstat_reg  [MAX_PROCS];
    logic                 occ_reg   [NUM_CPUS];
    logic [PID_W-1:0]     cproc_reg [NUM_CPUS];
    logic [SLICE_W-1:0]   slice_reg [NUM_CPUS];

    logic [CPU_W-1:0]     cpu_reg;
    logic [LVL_W-1:0]     lv_reg;
    logic                 pv_reg;
    logic [PID_W-1:0]     pp_reg;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [PID_W-1:0]     wr_data, rd_data;

    logic                 s_acc, m_acc, cfg_wr;

    assign s_acc  = s_valid && s_ready;
    assign m_acc  = m_valid && m_ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign s_ready = (state_reg == S_IDLE);
    assign pready  = 1'b1;

    // register read back
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_POLICY:  prdata = {31'd0, policy_reg};
            REG_QUANTUM: prdata = {24'd0, quantum_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // admit helpers
    logic [LVL_W-1:0] adm_lv, adm_q;
    logic             adm_ok;
    assign adm_lv = (32'(s_start_level) < NUM_LEVELS) ? s_start_level
                                                      : LVL_W'(NUM_LEVELS - 1);
    assign adm_q  = (policy_reg == POLICY_PRIO) ? adm_lv : '0;
    assign adm_ok = (32'(s_process_id) < MAX_PROCS)
                 && (pstat_reg[s_process_id] == PS_FREE)
                 && (32'(count_reg[adm_q]) < MAX_PROCS);

    // preempt helpers for the cpu in hand
    logic [PID_W-1:0] pre_p;
    logic [LVL_W-1:0] pre_lv, pre_q;
    logic             pre_push;
    assign pre_p  = cproc_reg[cpu_reg];
    assign pre_lv = (32'(plevel_reg[pre_p]) + 1 < NUM_LEVELS)
                  ? plevel_reg[pre_p] + LVL_W'(1) : plevel_reg[pre_p];
    assign pre_q  = (policy_reg == POLICY_PRIO) ? pre_lv : '0;
    assign pre_push = 32'(count_reg[pre_q]) < MAX_PROCS;

    // ram ports
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {adm_q, head_reg[adm_q] + count_reg[adm_q][PID_W-1:0]};
        wr_data = s_process_id;
        if (state_reg == S_IDLE) begin
            wr_en = s_acc && (s_mode == MODE_ADMIT) && adm_ok;
        end else if (state_reg == S_CHECK) begin
            wr_en   = occ_reg[cpu_reg] && (slice_reg[cpu_reg] == '0) && pre_push;
            wr_addr = {pre_q, head_reg[pre_q] + count_reg[pre_q][PID_W-1:0]};
            wr_data = pre_p;
        end
    end
    assign rd_addr = {lv_reg, head_reg[lv_reg]};

    mfcs_ram #(.WIDTH(PID_W), .DEPTH(DEPTH)) u_ready_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_acc) state_next = (s_mode == MODE_PASS) ? S_CHECK : S_OUT;
            S_CHECK: state_next = S_SCAN;
            S_SCAN: begin
                if (occ_reg[cpu_reg]) state_next = S_OUT;
                else if (count_reg[lv_reg] != '0) state_next = S_FILL;
                else if (32'(lv_reg) == NUM_LEVELS - 1) state_next = S_OUT;
            end
            S_FILL:  state_next = S_OUT;
            S_OUT: begin
                if (m_acc) state_next = m_last ? S_IDLE : S_CHECK;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state and scheduler tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            policy_reg  <= 1'b0;
            quantum_reg <= QUANTUM_RESET;
            m_valid     <= 1'b0;
            cpu_reg     <= '0;
            lv_reg      <= '0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            for (int p = 0; p < MAX_PROCS; p++) begin
                plevel_reg[p] <= '0;
                pstat_reg[p]  <= PS_FREE;
            end
            for (int c = 0; c < NUM_CPUS; c++) begin
                occ_reg[c]   <= 1'b0;
                cproc_reg[c] <= '0;
                slice_reg[c] <= QUANTUM_RESET;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                if (paddr[2] == REG_POLICY) policy_reg <= pwdata[0];
                else quantum_reg <= pwdata[SLICE_W-1:0];
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        m_valid <= (s_mode != MODE_PASS);
                        cpu_reg <= '0;
                        if (s_mode == MODE_ADMIT && adm_ok) begin
                            count_reg[adm_q]          <= count_reg[adm_q] + CNT_W'(1);
                            plevel_reg[s_process_id]  <= adm_lv;
                            pstat_reg[s_process_id]   <= PS_READY;
                        end
                        if ((s_mode == MODE_RETIRE || s_mode == MODE_BLOCK
                             || s_mode == MODE_TERM) && occ_reg[s_cpu_index]) begin
                            if (s_mode == MODE_RETIRE) begin
                                if (slice_reg[s_cpu_index] != '0)
                                    slice_reg[s_cpu_index] <=
                                        slice_reg[s_cpu_index] - SLICE_W'(1);
                            end else begin
                                pstat_reg[cproc_reg[s_cpu_index]] <=
                                    (s_mode == MODE_BLOCK) ? PS_BLOCK : PS_FREE;
                                occ_reg[s_cpu_index]   <= 1'b0;
                                cproc_reg[s_cpu_index] <= '0;
                                slice_reg[s_cpu_index] <= (quantum_reg != '0)
                                    ? quantum_reg - SLICE_W'(1) : '0;
                            end
                        end
                    end
                end
                S_CHECK: begin
                    lv_reg <= '0;
                    if (occ_reg[cpu_reg] && slice_reg[cpu_reg] == '0) begin
                        if (policy_reg == POLICY_PRIO) plevel_reg[pre_p] <= pre_lv;
                        if (pre_push) count_reg[pre_q] <= count_reg[pre_q] + CNT_W'(1);
                        pstat_reg[pre_p]   <= PS_READY;
                        occ_reg[cpu_reg]   <= 1'b0;
                        cproc_reg[cpu_reg] <= '0;
                        slice_reg[cpu_reg] <= quantum_reg;
                    end
                end
                S_SCAN: begin
                    if (occ_reg[cpu_reg]) begin
                        m_valid <= 1'b1;
                    end else if (count_reg[lv_reg] != '0) begin
                        head_reg[lv_reg]  <= head_reg[lv_reg] + PID_W'(1);
                        count_reg[lv_reg] <= count_reg[lv_reg] - CNT_W'(1);
                    end else if (32'(lv_reg) == NUM_LEVELS - 1) begin
                        m_valid <= 1'b1;
                    end else begin
                        lv_reg <= lv_reg + LVL_W'(1);
                    end
                end
                S_FILL: begin
                    occ_reg[cpu_reg]   <= 1'b1;
                    cproc_reg[cpu_reg] <= rd_data;
                    pstat_reg[rd_data] <= PS_RUN;
                    m_valid            <= 1'b1;
                end
                S_OUT: begin
                    if (m_acc) begin
                        m_valid <= 1'b0;
                        cpu_reg <= cpu_reg + CPU_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    m_cpu_number        <= '0;
                    m_cpu_busy          <= 1'b0;
                    m_running_process   <= '0;
                    m_preempt_valid     <= 1'b0;
                    m_preempted_process <= '0;
                    m_last              <= 1'b1;
                    m_status            <= STATUS_IGNORED;
                    pv_reg              <= 1'b0;
                    pp_reg              <= '0;
                    if (s_mode == MODE_ADMIT) begin
                        m_status <= adm_ok ? STATUS_DONE : STATUS_IGNORED;
                    end else if (s_mode == MODE_RETIRE || s_mode == MODE_BLOCK
                                 || s_mode == MODE_TERM) begin
                        m_cpu_number <= s_cpu_index;
                        if (occ_reg[s_cpu_index]) begin
                            m_status <= STATUS_DONE;
                            if (s_mode == MODE_RETIRE) begin
                                m_cpu_busy        <= 1'b1;
                                m_running_process <= cproc_reg[s_cpu_index];
                            end
                        end
                    end
                end
            end
            S_CHECK: begin
                pv_reg <= occ_reg[cpu_reg] && (slice_reg[cpu_reg] == '0);
                pp_reg <= (occ_reg[cpu_reg] && slice_reg[cpu_reg] == '0) ? pre_p : '0;
            end
            S_SCAN, S_FILL: begin
                m_cpu_number        <= cpu_reg;
                m_cpu_busy          <= (state_reg == S_FILL) || occ_reg[cpu_reg];
                m_running_process   <= (state_reg == S_FILL) ? rd_data : cproc_reg[cpu_reg];
                m_preempt_valid     <= pv_reg;
                m_preempted_process <= pp_reg;
                m_status            <= STATUS_DONE;
                m_last              <= (32'(cpu_reg) == NUM_CPUS - 1);
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/mfcs_checker.sv =====
`default_nettype none
`include "multilevel_feedback_cpu_scheduler_macros.svh"
module mfcs_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire       m_cpu_busy,
    input wire [3:0] m_running_process,
    input wire       m_preempt_valid,
    input wire       m_status
);
    // one request in flight at a time
    `MFCS_ASSERT_ALWAYS(a_no_overlap, aclk, aresetn, !(s_ready && m_valid))
    `MFCS_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready)
    // an idle cpu shows no running process
    `MFCS_ASSERT_ALWAYS(a_idle_zero, aclk, aresetn,
        !(m_valid && !m_cpu_busy) || (m_running_process == 4'd0))
    // ignored requests never report a preemption
    `MFCS_ASSERT_ALWAYS(a_ignored_no_pre, aclk, aresetn,
        !(m_valid && m_status) || !m_preempt_valid)
    // a pending result holds
    `MFCS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

bind multilevel_feedback_cpu_scheduler mfcs_checker u_mfcs_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_cpu_busy        (m_cpu_busy),
    .m_running_process (m_running_process),
    .m_preempt_valid   (m_preempt_valid),
    .m_status          (m_status)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import mfcs_pkg::*;

    // one scheduler result as seen on the m_ channel
    typedef struct packed {
        logic [CPU_W-1:0] cpu_number;
        logic             cpu_busy;
        logic [PID_W-1:0] running_process;
        logic             preempt_valid;
        logic [PID_W-1:0] preempted_process;
        logic             status;
        logic             last;
    } sched_res_t;

    // one row of the directed table
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [CPU_W-1:0]  cpu;
        logic [PID_W-1:0]  pid;
        logic [LVL_W-1:0]  lvl;
        bit                typed;
        sched_res_t        res;
    } req_row_t;

    localparam logic [PADDR_W-1:0] ADDR_POLICY  = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_QUANTUM = 3'd4;
    localparam logic POLICY_RR = 1'b1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [MODE_W-1:0] s_mode = '0;
    logic [CPU_W-1:0]  s_cpu_index = '0;
    logic [PID_W-1:0]  s_process_id = '0;
    logic [LVL_W-1:0]  s_start_level = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CPU_W-1:0] m_cpu_number;
    logic m_cpu_busy;
    logic [PID_W-1:0] m_running_process;
    logic m_preempt_valid;
    logic [PID_W-1:0] m_preempted_process;
    logic m_status;
    logic m_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // shadow scheduler state
    logic              cfg_policy;
    logic [SLICE_W-1:0] cfg_quantum;
    logic [PID_W-1:0]  ready_q [NUM_LEVELS][$];
    logic [LVL_W-1:0]  proc_lvl [MAX_PROCS];
    proc_state_t       proc_st [MAX_PROCS];
    logic              cpu_occ [NUM_CPUS];
    logic [PID_W-1:0]  cpu_pid [NUM_CPUS];
    logic [SLICE_W-1:0] cpu_slice [NUM_CPUS];

    sched_res_t sched_exp_q[$];
    sched_res_t new_res[$];
    int n_errors = 0;
    int n_reqs = 0;
    int n_results = 0;
    int n_preempts = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    multilevel_feedback_cpu_scheduler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_cpu_index(s_cpu_index), .s_process_id(s_process_id),
        .s_start_level(s_start_level),
        .m_valid(m_valid), .m_ready(m_ready), .m_cpu_number(m_cpu_number),
        .m_cpu_busy(m_cpu_busy), .m_running_process(m_running_process),
        .m_preempt_valid(m_preempt_valid), .m_preempted_process(m_preempted_process),
        .m_status(m_status), .m_last(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // overall time limit
    initial begin
        #5000000;
        $display("timeout with %0d results outstanding", sched_exp_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic sched_res_t mk_res(int c, int b, int r, int pv, int pp, int st, int l);
        sched_res_t x;
        x.cpu_number = CPU_W'(c);
        x.cpu_busy = 1'(b);
        x.running_process = PID_W'(r);
        x.preempt_valid = 1'(pv);
        x.preempted_process = PID_W'(pp);
        x.status = 1'(st);
        x.last = 1'(l);
        return x;
    endfunction

    task automatic reset_shadow();
        cfg_policy = POLICY_PRIO;
        cfg_quantum = QUANTUM_RESET;
        for (int l = 0; l < NUM_LEVELS; l++) ready_q[l].delete();
        for (int p = 0; p < MAX_PROCS; p++) begin
            proc_lvl[p] = '0;
            proc_st[p] = PS_FREE;
        end
        for (int c = 0; c < NUM_CPUS; c++) begin
            cpu_occ[c] = 1'b0;
            cpu_pid[c] = '0;
            cpu_slice[c] = QUANTUM_RESET;
        end
    endtask

    // work out the results of one scheduling request into new_res
    task automatic schedule_event(input logic [MODE_W-1:0] m, input logic [CPU_W-1:0] c,
                                  input logic [PID_W-1:0] pid, input logic [LVL_W-1:0] lv);
        logic [PID_W-1:0] p;
        logic [LVL_W-1:0] q;
        logic pv;
        logic [PID_W-1:0] pp;
        logic st;
        new_res.delete();
        case (m)
            MODE_PASS: begin
                for (int i = 0; i < NUM_CPUS; i++) begin
                    pv = 1'b0;
                    pp = '0;
                    // expired slice: demote, requeue, free the cpu
                    if (cpu_occ[i] && cpu_slice[i] == 0) begin
                        p = cpu_pid[i];
                        q = '0;
                        if (cfg_policy == POLICY_PRIO) begin
                            if (proc_lvl[p] < NUM_LEVELS - 1) proc_lvl[p]++;
                            q = proc_lvl[p];
                        end
                        if (ready_q[q].size() < MAX_PROCS) ready_q[q].push_back(p);
                        proc_st[p] = PS_READY;
                        cpu_occ[i] = 1'b0;
                        cpu_pid[i] = '0;
                        cpu_slice[i] = cfg_quantum;
                        pv = 1'b1;
                        pp = p;
                        n_preempts++;
                    end
                    // refill from the lowest non-empty level
                    if (!cpu_occ[i]) begin
                        for (int l = 0; l < NUM_LEVELS; l++) begin
                            if (!cpu_occ[i] && ready_q[l].size() != 0) begin
                                p = ready_q[l].pop_front();
                                cpu_occ[i] = 1'b1;
                                cpu_pid[i] = p;
                                proc_st[p] = PS_RUN;
                            end
                        end
                    end
                    new_res.push_back(mk_res(i, cpu_occ[i], cpu_pid[i], pv, pp,
                                             STATUS_DONE, i == NUM_CPUS - 1));
                end
            end
            MODE_RETIRE, MODE_BLOCK, MODE_TERM: begin
                if (!cpu_occ[c]) begin
                    new_res.push_back(mk_res(c, 0, 0, 0, 0, STATUS_IGNORED, 1));
                end else begin
                    if (m == MODE_RETIRE) begin
                        if (cpu_slice[c] != 0) cpu_slice[c]--;
                    end else begin
                        proc_st[cpu_pid[c]] = (m == MODE_BLOCK) ? PS_BLOCK : PS_FREE;
                        cpu_occ[c] = 1'b0;
                        cpu_pid[c] = '0;
                        cpu_slice[c] = (cfg_quantum != '0) ? cfg_quantum - SLICE_W'(1) : '0;
                    end
                    new_res.push_back(mk_res(c, cpu_occ[c], cpu_pid[c], 0, 0, STATUS_DONE, 1));
                end
            end
            MODE_ADMIT: begin
                st = STATUS_IGNORED;
                if (proc_st[pid] == PS_FREE) begin
                    q = (cfg_policy == POLICY_PRIO) ? lv : '0;
                    if (ready_q[q].size() < MAX_PROCS) begin
                        ready_q[q].push_back(pid);
                        proc_lvl[pid] = lv;
                        proc_st[pid] = PS_READY;
                        st = STATUS_DONE;
                    end
                end
                new_res.push_back(mk_res(0, 0, 0, 0, 0, st, 1));
            end
            default: new_res.push_back(mk_res(0, 0, 0, 0, 0, STATUS_IGNORED, 1));
        endcase
    endtask

    // offer one request, wait for it to be taken, record what it should give
    task automatic send_req(input req_row_t row);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= row.mode;
        s_cpu_index <= row.cpu;
        s_process_id <= row.pid;
        s_start_level <= row.lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        schedule_event(row.mode, row.cpu, row.pid, row.lvl);
        if (row.typed) sched_exp_q.push_back(row.res);
        else foreach (new_res[k]) sched_exp_q.push_back(new_res[k]);
        n_reqs++;
    endtask

    // register write; called at a clock edge with the block idle
    task automatic reg_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        s_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        if (a == ADDR_POLICY) cfg_policy = d[0];
        else cfg_quantum = d[SLICE_W-1:0];
    endtask

    // drain outstanding results, allow for in-flight work, then reconfigure
    task automatic set_config(input logic pol, input logic [SLICE_W-1:0] qn);
        s_valid <= 1'b0;
        while (sched_exp_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        reg_write(ADDR_POLICY, {31'd0, pol});
        reg_write(ADDR_QUANTUM, {24'd0, qn});
    endtask

    function automatic req_row_t rand_row();
        req_row_t r;
        int w;
        w = $urandom_range(0, 99);
        if (w < 38) r.mode = MODE_RETIRE;
        else if (w < 58) r.mode = MODE_PASS;
        else if (w < 76) r.mode = MODE_ADMIT;
        else if (w < 90) r.mode = MODE_TERM;
        else if (w < 94) r.mode = MODE_BLOCK;
        else r.mode = MODE_W'($urandom_range(5, 7));
        r.cpu = CPU_W'($urandom_range(0, 3));
        r.pid = PID_W'($urandom_range(0, 15));
        r.lvl = LVL_W'($urandom_range(0, 3));
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    task automatic report_mismatch(input string fld, input int got, input int want);
        n_errors++;
        if (n_errors <= 30)
            $display("%0t: result %0d field %s got %0d want %0d", $time, n_results, fld, got, want);
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        int gap_left;
        int hold_left;
        gap_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                m_ready <= 1'b0;
                gap_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) gap_left = pick_gap();
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        sched_res_t w;
        if (aresetn && m_valid && m_ready) begin
            if (sched_exp_q.size() == 0) begin
                report_mismatch("unexpected_result", 1, 0);
            end else begin
                w = sched_exp_q.pop_front();
                if (m_cpu_number !== w.cpu_number)
                    report_mismatch("cpu_number", m_cpu_number, w.cpu_number);
                if (m_cpu_busy !== w.cpu_busy)
                    report_mismatch("cpu_busy", m_cpu_busy, w.cpu_busy);
                if (m_running_process !== w.running_process)
                    report_mismatch("running_process", m_running_process, w.running_process);
                if (m_preempt_valid !== w.preempt_valid)
                    report_mismatch("preempt_valid", m_preempt_valid, w.preempt_valid);
                if (m_preempted_process !== w.preempted_process)
                    report_mismatch("preempted_process", m_preempted_process,
                                    w.preempted_process);
                if (m_status !== w.status)
                    report_mismatch("status", m_status, w.status);
                if (m_last !== w.last)
                    report_mismatch("last", m_last, w.last);
            end
            n_results++;
        end
    end

    // stimulus
    initial begin
        req_row_t dir_tab[$];
        req_row_t row;
        sched_res_t ign1;
        sched_res_t ok0;
        ign1 = mk_res(0, 0, 0, 0, 0, STATUS_IGNORED, 1);
        ok0 = mk_res(0, 0, 0, 0, 0, STATUS_DONE, 1);
        reset_shadow();

        // directed table: typed where the answer is plain, else predicted
        dir_tab.push_back('{MODE_RETIRE, 2'd0, 4'd0, 2'd0, 1'b1, ign1});
        dir_tab.push_back('{MODE_BLOCK, 2'd3, 4'd0, 2'd0, 1'b1,
                            mk_res(3, 0, 0, 0, 0, STATUS_IGNORED, 1)});
        dir_tab.push_back('{MODE_PASS, 2'd0, 4'd0, 2'd0, 1'b0, '0});
        dir_tab.push_back('{3'd5, 2'd3, 4'd15, 2'd3, 1'b1, ign1});
        dir_tab.push_back('{3'd7, 2'd0, 4'd0, 2'd0, 1'b1, ign1});
        dir_tab.push_back('{MODE_ADMIT, 2'd0, 4'd0, 2'd0, 1'b1, ok0});
        dir_tab.push_back('{MODE_ADMIT, 2'd3, 4'd15, 2'd3, 1'b1, ok0});
        dir_tab.push_back('{MODE_ADMIT, 2'd0, 4'd0, 2'd1, 1'b1, ign1});
        dir_tab.push_back('{MODE_ADMIT, 2'd0, 4'd5, 2'd2, 1'b0, '0});
        dir_tab.push_back('{MODE_ADMIT, 2'd0, 4'd9, 2'd1, 1'b0, '0});
        dir_tab.push_back('{MODE_ADMIT, 2'd0, 4'd10, 2'd0, 1'b0, '0});
        dir_tab.push_back('{MODE_PASS, 2'd0, 4'd0, 2'd0, 1'b0, '0});
        for (int k = 0; k < 5; k++) dir_tab.push_back('{MODE_RETIRE, 2'd0, 4'd0, 2'd0, 1'b0, '0});
        dir_tab.push_back('{MODE_RETIRE, 2'd1, 4'd0, 2'd0, 1'b0, '0});
        dir_tab.push_back('{MODE_PASS, 2'd0, 4'd0, 2'd0, 1'b0, '0});
        dir_tab.push_back('{MODE_BLOCK, 2'd1, 4'd0, 2'd0, 1'b0, '0});
        dir_tab.push_back('{MODE_TERM, 2'd2, 4'd0, 2'd0, 1'b0, '0});
        dir_tab.push_back('{MODE_TERM, 2'd3, 4'd0, 2'd0, 1'b0, '0});
        dir_tab.push_back('{MODE_PASS, 2'd0, 4'd0, 2'd0, 1'b0, '0});
        dir_tab.push_back('{3'd6, 2'd1, 4'd3, 2'd2, 1'b1, ign1});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[k]) send_req(dir_tab[k]);

        // random phases across both policies and the quantum extremes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_config(POLICY_PRIO, 8'd1);
                1: set_config(POLICY_RR, 8'd255);
                2: set_config(POLICY_RR, 8'd1);
                3: set_config(POLICY_PRIO, SLICE_W'($urandom_range(2, 6)));
                default: set_config(POLICY_PRIO, 8'd3);
            endcase
            calm = (ph == 3);
            for (int n = 0; n < 88; n++) begin
                if (ph == 1 && n == 20) hold_req = 1'b1;
                if (ph == 2 && n == 40) begin
                    // sender waits for everything outstanding
                    s_valid <= 1'b0;
                    while (sched_exp_q.size() != 0) @(posedge aclk);
                end
                row = rand_row();
                // in the slow-expiry phase, re-pick the cpu of some retires at random
                if (ph == 1 && row.mode == MODE_RETIRE && $urandom_range(0, 1))
                    row.cpu = CPU_W'($urandom_range(0, 3));
                send_req(row);
            end
        end
        calm = 1'b0;

        s_valid <= 1'b0;
        while (sched_exp_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("%0d requests sent, %0d results checked, %0d preemptions seen",
                 n_reqs, n_results, n_preempts);
        $display("both policies, quanta 1 to 255, stalls and long hold-offs exercised");
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mfcs_pkg.sv
sv/mfcs_ram.sv
sv/multilevel_feedback_cpu_scheduler.sv
sv/mfcs_checker.sv
sim/testbench.sv
